### design/rrtss_pkg.sv
// ----------------------------------------------------------------------------
// rrtss_pkg
// Shared types and codes for the round-robin thread slot scheduler.
// ----------------------------------------------------------------------------
package rrtss_pkg;

  // Field widths of the channels
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int TID_W  = 16;
  localparam int SLOT_W = 4;
  // Common width for id compares and output truncation (ID_BITS <= 32)
  localparam int CMP_W  = 32;

  // Event codes
  localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_YIELD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EXIT   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_JOIN   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FND  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_PENDING  = 2'd3;

  // Slot states
  localparam logic [1:0] SLOT_FREE     = 2'd0;
  localparam logic [1:0] SLOT_RUNNABLE = 2'd1;
  localparam logic [1:0] SLOT_RUNNING  = 2'd2;
  localparam logic [1:0] SLOT_ZOMBIE   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch event and slot masks
    logic pick;    // resolve priority picks
    logic commit;  // update table and result register
  } cmd_t;

endpackage

### design/rrtss_if.sv
// ----------------------------------------------------------------------------
// rrtss_in_if / rrtss_out_if
// Valid/ready channels for scheduler events and their results.
// ----------------------------------------------------------------------------
interface rrtss_in_if;
  import rrtss_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [TID_W-1:0]  join_tid;

  modport source (output valid, output action, output join_tid, input ready);
  modport sink   (input valid, input action, input join_tid, output ready);
endinterface

interface rrtss_out_if;
  import rrtss_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TID_W-1:0]  new_tid;
  logic [SLOT_W-1:0] running_slot;
  logic [TID_W-1:0]  running_tid;
  logic              switched;

  modport source (output valid, output status, output new_tid, output running_slot,
                  output running_tid, output switched, input ready);
  modport sink   (input valid, input status, input new_tid, input running_slot,
                  input running_tid, input switched, output ready);
endinterface

### design/rrtss_ctrl.sv
// ----------------------------------------------------------------------------
// rrtss_ctrl
// Event sequencer: accept, pick, commit; owns the result valid flag.
// ----------------------------------------------------------------------------
module rrtss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rrtss_pkg::cmd_t cmd
);
  import rrtss_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PICK   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;

  always_comb begin
    cmd.load   = in_valid && (state_r == S_IDLE);
    cmd.pick   = (state_r == S_PICK);
    // result register must be free or draining
    cmd.commit = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/rrtss_dp.sv
// ----------------------------------------------------------------------------
// rrtss_dp
// Slot table, per-slot compare masks, priority picks and result register.
// ----------------------------------------------------------------------------
module rrtss_dp #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrtss_pkg::cmd_t             cmd,
  input  logic [rrtss_pkg::ACT_W-1:0] in_action,
  input  logic [rrtss_pkg::TID_W-1:0] in_join_tid,
  output logic [rrtss_pkg::STAT_W-1:0] out_status,
  output logic [rrtss_pkg::TID_W-1:0]  out_new_tid,
  output logic [rrtss_pkg::SLOT_W-1:0] out_running_slot,
  output logic [rrtss_pkg::TID_W-1:0]  out_running_tid,
  output logic                         out_switched
);
  import rrtss_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam logic [ID_BITS-1:0] ID_MAX   = {ID_BITS{1'b1}};
  localparam logic [ID_BITS-1:0] ID_ONE   = ID_BITS'(1);
  localparam logic [ID_BITS-1:0] ID_FIRST = ID_BITS'(2);

  // Slot table
  logic [1:0]         st_r  [SLOTS];
  logic [1:0]         st_nxt[SLOTS];
  logic [ID_BITS-1:0] tid_r [SLOTS];
  logic [SW-1:0]      cur_r, cur_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;

  // Stage 1: event and slot masks
  logic [ACT_W-1:0]   act_r;
  logic [SLOTS-1:0]   free_m, run_m, run_hi_m, match_m, zmatch_m;
  logic [SLOTS-1:0]   free_m_r, run_m_r, run_hi_m_r, match_m_r, zmatch_m_r;

  // Stage 2: picks
  logic [SW-1:0]      free_idx_r, cand_idx_r, match_idx_r;
  logic               free_any_r, cand_any_r, match_any_r, match_zmb_r;
  logic [SLOTS-1:0]   match_oh;

  // Commit
  logic               is_create, is_exit, is_join, placed, do_yield, sw;
  logic [STAT_W-1:0]  status_nxt;
  logic [ID_BITS-1:0] run_tid;
  logic [CMP_W-1:0]   given_w, run_tid_w, cur_w;

  function automatic logic [SW-1:0] first_idx(input logic [SLOTS-1:0] m);
    logic [SW-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = SW'(i);
    end
    return r;
  endfunction

  // Per-slot compares against the event
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_m[i]   = (st_r[i] == SLOT_FREE);
      // exit turns the current slot into a zombie before the pick
      run_m[i]    = (st_r[i] == SLOT_RUNNABLE) &&
                    !((in_action == ACT_EXIT) && (SW'(i) == cur_r));
      run_hi_m[i] = run_m[i] && (SW'(i) > cur_r);
      match_m[i]  = (st_r[i] != SLOT_FREE) &&
                    (CMP_W'(tid_r[i]) == CMP_W'(in_join_tid));
      zmatch_m[i] = (st_r[i] == SLOT_ZOMBIE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r      <= in_action;
      free_m_r   <= free_m;
      run_m_r    <= run_m;
      run_hi_m_r <= run_hi_m;
      match_m_r  <= match_m;
      zmatch_m_r <= zmatch_m;
    end
  end

  // Lowest matching slot, isolated as one-hot
  assign match_oh = match_m_r & (~match_m_r + SLOTS'(1));

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      free_idx_r  <= first_idx(free_m_r);
      free_any_r  <= |free_m_r;
      // round robin: slots above current first, then wrap from slot 0
      cand_idx_r  <= (|run_hi_m_r) ? first_idx(run_hi_m_r) : first_idx(run_m_r);
      cand_any_r  <= |run_m_r;
      match_idx_r <= first_idx(match_m_r);
      match_any_r <= |match_m_r;
      match_zmb_r <= |(match_oh & zmatch_m_r);
    end
  end

  always_comb begin
    is_create = (act_r == ACT_CREATE);
    is_exit   = (act_r == ACT_EXIT);
    is_join   = (act_r == ACT_JOIN);
    placed    = is_create && free_any_r;
    do_yield  = (act_r == ACT_YIELD) || is_exit ||
                (is_join && match_any_r && !match_zmb_r);
    sw        = do_yield && cand_any_r;
    cur_nxt   = sw ? cand_idx_r : cur_r;

    next_id_nxt = next_id_r;
    if (placed) next_id_nxt = (next_id_r == ID_MAX) ? ID_ONE : next_id_r + ID_ONE;

    for (int i = 0; i < SLOTS; i++) begin
      st_nxt[i] = st_r[i];
      if (placed && (SW'(i) == free_idx_r)) st_nxt[i] = SLOT_RUNNABLE;
      if (is_join && match_any_r && match_zmb_r && (SW'(i) == match_idx_r)) begin
        st_nxt[i] = SLOT_FREE;
      end
      if (is_exit && (SW'(i) == cur_r)) st_nxt[i] = SLOT_ZOMBIE;
      if (sw && (SW'(i) == cur_r) && (st_nxt[i] == SLOT_RUNNING)) st_nxt[i] = SLOT_RUNNABLE;
      if (sw && (SW'(i) == cand_idx_r)) st_nxt[i] = SLOT_RUNNING;
    end

    status_nxt = STAT_OK;
    if (is_create && !free_any_r) begin
      status_nxt = STAT_NO_FREE;
    end else if (is_join) begin
      if (!match_any_r)      status_nxt = STAT_NOT_FND;
      else if (!match_zmb_r) status_nxt = STAT_PENDING;
    end

    // a create never moves the current slot, so only that write can alias
    run_tid = (placed && (free_idx_r == cur_nxt)) ? next_id_r : tid_r[cur_nxt];

    given_w   = placed ? CMP_W'(next_id_r) : '0;
    run_tid_w = CMP_W'(run_tid);
    cur_w     = CMP_W'(cur_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i]  <= (i == 0) ? SLOT_RUNNING : SLOT_FREE;
        tid_r[i] <= (i == 0) ? ID_ONE : '0;
      end
      cur_r     <= '0;
      next_id_r <= ID_FIRST;
    end else if (cmd.commit) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i] <= st_nxt[i];
        if (placed && (SW'(i) == free_idx_r)) tid_r[i] <= next_id_r;
      end
      cur_r     <= cur_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status       <= status_nxt;
      out_new_tid      <= given_w[TID_W-1:0];
      out_running_slot <= cur_w[SLOT_W-1:0];
      out_running_tid  <= run_tid_w[TID_W-1:0];
      out_switched     <= (cur_nxt != cur_r);
    end
  end

endmodule

### design/round_robin_thread_slot_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler
// Thread slot table with create, yield, exit and join events and a
// round-robin pick of the next runnable slot.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    action, join_tid
//  out_ch   out  valid/ready    status, new_tid, running_slot, running_tid, switched
//
//  An item is accepted, then picked, then committed: the accept latches per-slot
//  compare masks, the pick state resolves the free, match and round-robin priority
//  picks, and the commit state updates the table and loads the result register.
//  New items are accepted while a result waits; commit stalls until it drains.
//  Synchronous active-low reset: slot 0 running with id 1, next id 2.
// ----------------------------------------------------------------------------
module round_robin_thread_slot_scheduler #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rrtss_in_if.sink    in_ch,
  rrtss_out_if.source out_ch
);
  import rrtss_pkg::*;

  cmd_t cmd;

  rrtss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rrtss_dp #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_ch.action),
    .in_join_tid      (in_ch.join_tid),
    .out_status       (out_ch.status),
    .out_new_tid      (out_ch.new_tid),
    .out_running_slot (out_ch.running_slot),
    .out_running_tid  (out_ch.running_tid),
    .out_switched     (out_ch.switched)
  );

  // An accepted item keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // A failed create never changes the running slot
  a_create_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STAT_NO_FREE) |-> !out_ch.switched)
    else $error("switch on a failed create");

  // An unknown join id leaves the schedule alone
  a_notfound_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STAT_NOT_FND) |-> !out_ch.switched)
    else $error("switch on a join with unknown id");

  // A given id comes only with an ok status
  a_new_tid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.new_tid != '0) |-> (out_ch.status == STAT_OK))
    else $error("new id reported with failing status");

endmodule
